>>> src/lit_pkg.sv
// ----------------------------------------------------------------------------
// lit_pkg
// Shared constants and types of the linear interpolation table lookup unit.
// ----------------------------------------------------------------------------
package lit_pkg;

    localparam int TABLE_DEPTH_DEF = 256;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FEW   = 2'd1,
        ST_ZERO  = 2'd2,
        ST_UNUSED = 2'd3
    } t_status;

    // Start request and operands toward the multiply-divide unit.
    typedef struct packed {
        logic        start;
        logic [32:0] a;
        logic [32:0] b;
        logic [32:0] d;
    } t_md_req;

endpackage

>>> src/lit_muldiv.sv
// ----------------------------------------------------------------------------
// lit_muldiv
// Computes min(a * b / d, 2^34) on magnitudes, with one 33x33 multiply and a
// restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lit_muldiv (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lit_pkg::t_md_req i_req,
    output logic            o_done,
    output logic [34:0]     o_quo
);

    logic [65:0] r_prod;
    logic [32:0] r_d;
    logic [34:0] r_rem;
    logic [34:0] r_quo;
    logic        r_over;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_mul;
    logic        r_done;

    logic [34:0] n_shift;
    logic        n_ge;
    logic [34:0] n_rem;

    always_comb begin
        n_shift = {r_rem[33:0], r_prod[65]};
        n_ge    = n_shift >= {2'b0, r_d};
        n_rem   = n_ge ? n_shift - {2'b0, r_d} : n_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_mul  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_prod <= {33'd0, i_req.a} * {33'd0, i_req.b};
                r_d    <= i_req.d;
                r_rem  <= '0;
                r_quo  <= '0;
                r_over <= 1'b0;
                r_cnt  <= 7'd66;
                r_mul  <= 1'b1;
                r_busy <= 1'b1;
            end else if (r_mul) begin
                r_mul <= 1'b0;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_prod <= {r_prod[64:0], 1'b0};
                r_cnt  <= r_cnt - 7'd1;
                if (r_cnt > 7'd35) begin
                    if (n_ge) begin
                        r_over <= 1'b1;
                    end
                end else begin
                    r_quo <= {r_quo[33:0], n_ge};
                end
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = (r_over || r_quo > 35'h4_0000_0000) ? 35'h4_0000_0000 : r_quo;

endmodule

>>> src/linear_interp_table_lookup_unit.sv
// ----------------------------------------------------------------------------
// linear_interp_table_lookup_unit
// Piecewise linear interpolation over a loaded table of (x, y) points.
// ----------------------------------------------------------------------------
// Requests arrive on i_valid/o_stall with i_kind, i_point_x and i_point_y.
// A clear or append request passes through S_WAIT and gives no result. A query
// gives one result on o_valid/i_stall with o_interp_y and o_status.
// A query reads the first and last x, then runs a binary search of up to
// log2(TABLE_DEPTH) memory reads, each through S_SRCH, S_SWT and S_SCMP, then
// reads the segment ends and runs the multiply-divide unit; an early-out
// query skips the search and the multiply-divide unit.
// The x and y tables sit in one synchronous memory each, read in the cycle after
// the address is set. Reset empties the table and clears clip_above; the
// table contents stay undefined until written. While the result waits under
// i_stall the block holds o_stall high and accepts nothing further.
// i_cfg_we writes clip_above from i_cfg_wdata.
// ----------------------------------------------------------------------------
module linear_interp_table_lookup_unit #(
    parameter int TABLE_DEPTH = lit_pkg::TABLE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_interp_y,
    output logic [1:0]         o_status
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_FIRST, S_LAST, S_CHECK, S_SRCH, S_SWT, S_SCMP,
        S_RD0, S_RD1, S_RD2, S_MD, S_WAIT, S_OUT
    } t_state;

    logic [31:0] r_mem_x [TABLE_DEPTH];
    logic [31:0] r_mem_y [TABLE_DEPTH];
    logic [31:0] r_rx, r_ry;
    logic [AW-1:0] r_addr;
    logic        r_we;
    logic [AW-1:0] r_waddr;
    logic [31:0] r_wx, r_wy;

    t_state      r_state;
    logic [CW-1:0] r_count;
    logic        r_clip;
    logic signed [31:0] r_q, r_x0, r_y0, r_x1;
    logic [AW-1:0] r_lo, r_hi;
    logic        r_neg;
    logic        r_ovalid;
    logic signed [31:0] r_oy;
    logic [1:0]  r_ost;
    lit_pkg::t_md_req r_md;

    logic        md_done;
    logic [34:0] md_quo;

    logic [AW-1:0] n_mid;
    logic signed [32:0] n_dx, n_dy, n_dq;
    logic signed [35:0] n_sum;

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            r_mem_x[r_waddr] <= r_wx;
            r_mem_y[r_waddr] <= r_wy;
        end
        r_rx <= r_mem_x[r_addr];
        r_ry <= r_mem_y[r_addr];
    end

    assign n_mid = AW'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);

    always_comb begin
        n_dx = 33'(signed'(r_rx)) - 33'(r_x0);
        n_dy = 33'(signed'(r_ry)) - 33'(r_y0);
        n_dq = 33'(r_q) - 33'(r_x0);
        n_sum = r_neg ? 36'(r_y0) - signed'({1'b0, md_quo})
                      : 36'(r_y0) + signed'({1'b0, md_quo});
    end

    lit_muldiv u_md (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (r_md),
        .o_done (md_done),
        .o_quo  (md_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_clip   <= 1'b0;
            r_ovalid <= 1'b0;
            r_we     <= 1'b0;
            r_md.start <= 1'b0;
        end else begin
            r_we <= 1'b0;
            r_md.start <= 1'b0;
            if (i_cfg_we) begin
                r_clip <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_q <= i_point_x;
                        case (i_kind)
                            lit_pkg::KIND_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_WAIT;
                            end
                            lit_pkg::KIND_APPEND: begin
                                if (r_count < CW'(TABLE_DEPTH)) begin
                                    r_we    <= 1'b1;
                                    r_waddr <= r_count[AW-1:0];
                                    r_wx    <= i_point_x;
                                    r_wy    <= i_point_y;
                                    r_count <= r_count + CW'(1);
                                end
                                r_state <= S_WAIT;
                            end
                            lit_pkg::KIND_QUERY: begin
                                if (r_count < CW'(2)) begin
                                    r_oy     <= '0;
                                    r_ost    <= lit_pkg::ST_FEW;
                                    r_ovalid <= 1'b1;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_addr  <= '0;
                                    r_state <= S_FIRST;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_WAIT: r_state <= S_IDLE;
                S_FIRST: begin
                    r_addr  <= AW'(r_count - CW'(1));
                    r_state <= S_LAST;
                end
                S_LAST: begin
                    r_x0    <= r_rx;
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_q < r_x0) begin
                        r_oy <= '0; r_ost <= lit_pkg::ST_OK;
                        r_ovalid <= 1'b1; r_state <= S_OUT;
                    end else if (r_q >= signed'(r_rx)) begin
                        if (r_clip && r_q > signed'(r_rx)) begin
                            r_oy <= '0; r_ost <= lit_pkg::ST_OK;
                            r_ovalid <= 1'b1; r_state <= S_OUT;
                        end else begin
                            r_lo    <= AW'(r_count - CW'(2));
                            r_addr  <= AW'(r_count - CW'(2));
                            r_state <= S_RD0;
                        end
                    end else begin
                        r_lo    <= '0;
                        r_hi    <= AW'(r_count - CW'(1));
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (r_hi - r_lo > AW'(1)) begin
                        r_addr  <= n_mid;
                        r_state <= S_SWT;
                    end else begin
                        r_addr  <= r_lo;
                        r_state <= S_RD0;
                    end
                end
                S_SWT: r_state <= S_SCMP;
                S_SCMP: begin
                    if (signed'(r_rx) <= r_q) begin
                        r_lo <= r_addr;
                    end else begin
                        r_hi <= r_addr;
                    end
                    r_state <= S_SRCH;
                end
                S_RD0: begin
                    r_addr  <= r_lo + AW'(1);
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_x0    <= r_rx;
                    r_y0    <= r_ry;
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    if (n_dx == '0) begin
                        r_oy <= '0; r_ost <= lit_pkg::ST_ZERO;
                        r_ovalid <= 1'b1; r_state <= S_OUT;
                    end else begin
                        r_neg <= (n_dy[32] != n_dq[32]) != n_dx[32];
                        r_md.start <= 1'b1;
                        r_md.a <= n_dy[32] ? 33'(-n_dy) : n_dy;
                        r_md.b <= n_dq[32] ? 33'(-n_dq) : n_dq;
                        r_md.d <= n_dx[32] ? 33'(-n_dx) : n_dx;
                        r_state <= S_MD;
                    end
                end
                S_MD: begin
                    if (md_done) begin
                        if (n_sum > 36'sh0_7FFF_FFFF) begin
                            r_oy <= 32'sh7FFF_FFFF;
                        end else if (n_sum < -36'sh0_8000_0000) begin
                            r_oy <= 32'sh8000_0000;
                        end else begin
                            r_oy <= n_sum[31:0];
                        end
                        r_ost    <= lit_pkg::ST_OK;
                        r_ovalid <= 1'b1;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_ovalid <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_ovalid;
    assign o_interp_y = r_oy;
    assign o_status   = r_ost;

endmodule

>>> src/lit_checker.sv
// ----------------------------------------------------------------------------
// lit_checker
// Port-level checks of the linear interpolation table lookup unit.
// ----------------------------------------------------------------------------
module lit_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_interp_y,
    input logic [1:0]  o_status
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_interp_y) && $stable(o_status))
        else $error("Result changed while stalled.");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("Request taken while a result is pending.");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != 2'd0 |-> o_interp_y == 32'd0)
        else $error("Error status with nonzero value.");

endmodule

bind linear_interp_table_lookup_unit lit_checker u_lit_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_stall   (o_stall),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_interp_y(o_interp_y),
    .o_status  (o_status)
);

>>> tb/sv/tb_linear_interp_table_lookup_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_interp_table_lookup_unit
// Loads tables of points, queries them, and checks every interpolated result
// against a predictor of the table, the segment search and the saturated
// interpolation, under random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module tb_linear_interp_table_lookup_unit;
    import lit_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam int LONG_HOLD = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 200;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] x;
        logic [31:0] y;
    } t_request;

    typedef struct packed {
        logic [31:0] interp_y;
        t_status     status;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_wdata = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [1:0] i_kind = KIND_CLEAR;
    logic signed [31:0] i_point_x = '0;
    logic signed [31:0] i_point_y = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [31:0] o_interp_y;
    logic [1:0] o_status;

    t_request pending_requests[$];
    t_answer expected_answers[$];
    logic [31:0] model_x[DEPTH];
    logic [31:0] model_y[DEPTH];
    int model_count = 0;
    logic model_clip = 1'b0;
    int mismatches = 0;
    int idle_cycles = 0;
    bit random_idle = 1'b1;
    bit hold_request = 1'b0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_count = 0;

    linear_interp_table_lookup_unit u_top (.*);

    always #5 i_clk = ~i_clk;

    function automatic t_answer interpolate(logic [31:0] q_bits);
        t_answer a;
        longint q, x0, x1, y0, y1, dy, dq, dx, mag, r;
        int lo, hi, mid;
        logic [127:0] prod;
        a.interp_y = '0;
        a.status = ST_OK;
        q = longint'($signed(q_bits));
        if (model_count < 2) begin
            a.status = ST_FEW;
            return a;
        end
        if (q < longint'($signed(model_x[0]))) return a;
        if (q >= longint'($signed(model_x[model_count - 1]))) begin
            if (model_clip && q > longint'($signed(model_x[model_count - 1]))) return a;
            lo = model_count - 2;
        end else begin
            lo = 0;
            hi = model_count - 1;
            while (hi - lo > 1) begin
                mid = (lo + hi) / 2;
                if (longint'($signed(model_x[mid])) <= q) lo = mid;
                else hi = mid;
            end
        end
        x0 = longint'($signed(model_x[lo]));
        x1 = longint'($signed(model_x[lo + 1]));
        y0 = longint'($signed(model_y[lo]));
        y1 = longint'($signed(model_y[lo + 1]));
        dx = x1 - x0;
        if (dx == 0) begin
            a.status = ST_ZERO;
            return a;
        end
        dy = y1 - y0;
        dq = q - x0;
        prod = 128'(dy < 0 ? -dy : dy) * 128'(dq < 0 ? -dq : dq);
        prod = prod / 128'(dx < 0 ? -dx : dx);
        mag = (prod > 128'(64'd1 << 34)) ? (longint'(1) << 34) : longint'(prod[63:0]);
        r = (((dy < 0) != (dq < 0)) != (dx < 0)) ? y0 - mag : y0 + mag;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        a.interp_y = r[31:0];
        return a;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            case (t_kind'(i_kind))
                KIND_CLEAR: model_count = 0;
                KIND_APPEND: begin
                    if (model_count < DEPTH) begin
                        model_x[model_count] = i_point_x;
                        model_y[model_count] = i_point_y;
                        model_count++;
                    end
                end
                KIND_QUERY: expected_answers.push_back(interpolate(i_point_x));
                default: ;
            endcase
        end
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (pending_requests.size() > 0 && !hold_request) begin
                t_request r;
                r = pending_requests.pop_front();
                i_valid <= 1'b1;
                i_kind <= r.kind;
                i_point_x <= r.x;
                i_point_y <= r.y;
                if (random_idle && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 5);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            t_answer e;
            if (expected_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result y=%h status=%0d",
                    o_interp_y, o_status);
            end else begin
                e = expected_answers.pop_front();
                if (o_interp_y !== e.interp_y || o_status !== e.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected y=%h status=%0d, got y=%h status=%0d",
                            e.interp_y, e.status, o_interp_y, o_status);
                end
            end
        end
        if (hold_count > 0) begin
            hold_count--;
            i_stall <= 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap--;
            i_stall <= 1'b1;
        end else if (random_idle && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(0, 4);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($urandom_range(0, 20) * 32'h0001_0000) - 32'h000a_0000;
            default: return $urandom();
        endcase
    endfunction

    task automatic add_request(t_kind k, logic [31:0] x, logic [31:0] y);
        pending_requests.push_back('{kind: k, x: x, y: y});
    endtask

    task automatic load_sorted_table(int n);
        logic [31:0] xs[$];
        logic [31:0] v;
        add_request(KIND_CLEAR, $urandom(), $urandom());
        for (int i = 0; i < n; i++) xs.push_back(random_word());
        xs.sort() with ($signed(item));
        foreach (xs[i]) begin
            v = xs[i];
            if ($urandom_range(0, 15) == 0 && i > 0) v = xs[i - 1];
            add_request(KIND_APPEND, v, random_word());
        end
    endtask

    task automatic wait_drained();
        while (pending_requests.size() > 0 || expected_answers.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_clip(logic v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        model_clip = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_request(KIND_QUERY, 32'h0, 32'h0);
        add_request(KIND_APPEND, 32'h0001_0000, 32'h7fff_ffff);
        add_request(KIND_QUERY, 32'h0001_0000, 32'h0);
        add_request(KIND_APPEND, 32'h0001_0000, 32'h8000_0000);
        add_request(KIND_QUERY, 32'h0001_0000, 32'h0);
        add_request(KIND_NONE, 32'h0003_0000, 32'h1234_5678);
        add_request(KIND_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
        add_request(KIND_APPEND, 32'h8000_0000, 32'h8000_0000);
        add_request(KIND_APPEND, 32'h0000_0000, 32'h7fff_ffff);
        add_request(KIND_APPEND, 32'h7fff_ffff, 32'h8000_0000);
        add_request(KIND_QUERY, 32'h8000_0000, 32'h0);
        add_request(KIND_QUERY, 32'hc000_0000, 32'h0);
        add_request(KIND_QUERY, 32'h7fff_ffff, 32'h0);
        add_request(KIND_QUERY, 32'h4000_0000, 32'h0);
        add_request(KIND_CLEAR, 32'h0, 32'h0);
        add_request(KIND_APPEND, 32'h0005_0000, 32'h0);
        add_request(KIND_APPEND, 32'h0001_0000, 32'h7fff_ffff);
        add_request(KIND_APPEND, 32'h0009_0000, 32'h8000_0000);
        add_request(KIND_QUERY, 32'h0004_0000, 32'h0);
        add_request(KIND_QUERY, 32'h000a_0000, 32'h0);
        add_request(KIND_QUERY, 32'h0000_0000, 32'h0);
        wait_drained();
        write_clip(1'b1);
        add_request(KIND_QUERY, 32'h000a_0000, 32'h0);
        add_request(KIND_QUERY, 32'h0009_0000, 32'h0);
        wait_drained();

        // Fill the table past its depth, then query it while the output side holds off.
        add_request(KIND_CLEAR, 32'h0, 32'h0);
        for (int i = 0; i < DEPTH + 4; i++)
            add_request(KIND_APPEND, 32'(i * 32'h0001_0000), random_word());
        for (int i = 0; i < 8; i++) add_request(KIND_QUERY, random_word(), 32'h0);
        wait_drained();
        hold_request = 1'b1;
        for (int i = 0; i < 6; i++) add_request(KIND_QUERY, random_word(), 32'h0);
        hold_count = LONG_HOLD;
        hold_request = 1'b0;
        wait_drained();

        for (int phase = 0; phase < 8; phase++) begin
            write_clip(phase[0]);
            for (int t = 0; t < 8; t++) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(2, 12);
                load_sorted_table(n);
                for (int k = 0; k < 8; k++) begin
                    if ($urandom_range(0, 19) == 0)
                        add_request(t_kind'($urandom_range(0, 3)), $urandom(), $urandom());
                    else
                        add_request(KIND_QUERY, random_word(), $urandom());
                end
            end
            if (phase == 6) random_idle = 1'b0;
            wait_drained();
        end

        if (mismatches == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end
endmodule
